// ===== hw/rtl/canopen_node_boot_configurator_core_assert.svh =====
// assertion macros used by the checker file
`ifndef CANOPEN_NODE_BOOT_CONFIGURATOR_CORE_ASSERT_SVH
`define CANOPEN_NODE_BOOT_CONFIGURATOR_CORE_ASSERT_SVH

// same-cycle implication, masked while reset is high
`define CNBC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cnbc assertion failed");

// next-cycle implication, also checked through reset
`define CNBC_ASSERT_NXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("cnbc assertion failed");

`endif

// ===== hw/rtl/cnbc_pkg.sv =====
`timescale 1ns / 1ps
package cnbc_pkg;

   localparam int MAX_NODES   = 4;
   localparam int CONF_DEPTH  = 16;
   localparam int SLOT_W      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int POS_W       = $clog2(CONF_DEPTH + 1);
   localparam int ENTRY_W     = (CONF_DEPTH > 1) ? $clog2(CONF_DEPTH) : 1;
   localparam int TABLE_DEPTH = MAX_NODES * CONF_DEPTH;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 28;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NODE_COUNT   = 2'd0,
      CSR_NODE_IDS     = 2'd1,
      CSR_CONF_LENGTHS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_FRAME     = 2'd0,
      CMD_LOAD      = 2'd1,
      CMD_RESET_ALL = 2'd2,
      CMD_SYNC      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PHASE_RESET_COM = 2'd0,
      PHASE_PREOP     = 2'd1,
      PHASE_OPER      = 2'd2
   } phase_type;

   // function codes, id bits 10..7
   localparam logic [3:0] FC_PDO1     = 4'h3;
   localparam logic [3:0] FC_PDO2     = 4'h5;
   localparam logic [3:0] FC_PDO3     = 4'h7;
   localparam logic [3:0] FC_SDO_RESP = 4'hB;
   localparam logic [3:0] FC_SDO_REQ  = 4'hC;
   localparam logic [3:0] FC_BOOTUP   = 4'hE;

   // expedited download command bytes by size
   localparam logic [7:0] SDO_DL_1 = 8'h2f;
   localparam logic [7:0] SDO_DL_2 = 8'h2b;
   localparam logic [7:0] SDO_DL_3 = 8'h27;
   localparam logic [7:0] SDO_DL_4 = 8'h23;

   localparam logic [7:0]  NMT_START     = 8'h01;
   localparam logic [7:0]  NMT_RESET_ALL = 8'h81;
   localparam logic [10:0] NMT_ID        = 11'h000;
   localparam logic [10:0] SYNC_ID       = 11'h080;
   localparam logic [6:0]  NODE_ID_MASK  = 7'h7f;

   typedef struct packed {
      logic [15:0] index;
      logic [7:0]  subindex;
      logic [2:0]  size;
      logic [31:0] value;
   } conf_entry_type;

endpackage

// ===== hw/rtl/cnbc_req_if.sv =====
`timescale 1ns / 1ps
interface cnbc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [10:0] can_id;
   logic [3:0]  frame_len;
   logic [63:0] payload;
   logic [1:0]  node_slot;
   logic [3:0]  entry_slot;
   logic [15:0] entry_index;
   logic [7:0]  entry_subindex;
   logic [2:0]  entry_size;
   logic [31:0] entry_value;

   modport source (
      output valid, cmd, can_id, frame_len, payload, node_slot, entry_slot,
             entry_index, entry_subindex, entry_size, entry_value,
      input  ready
   );
   modport sink (
      input  valid, cmd, can_id, frame_len, payload, node_slot, entry_slot,
             entry_index, entry_subindex, entry_size, entry_value,
      output ready
   );
endinterface

// ===== hw/rtl/cnbc_rsp_if.sv =====
`timescale 1ns / 1ps
interface cnbc_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [10:0] out_id;
   logic [3:0]  out_len;
   logic [63:0] out_data;
   logic [1:0]  out_slot;
   logic [3:0]  out_function;

   modport source (
      output valid, kind, out_id, out_len, out_data, out_slot, out_function,
      input  ready
   );
   modport sink (
      input  valid, kind, out_id, out_len, out_data, out_slot, out_function,
      output ready
   );
endinterface

// ===== hw/rtl/canopen_node_boot_configurator_core.sv =====
`timescale 1ns / 1ps
// a request passes through stage 1 and then the result register before it is offered on rsp_bus
// throughput: one request transaction per cycle while the result register drains;
//   both read ports of the configuration table memory are read at acceptance
// reset: synchronous, clears configuration registers, node phases, positions and valid flags;
//   the configuration table is not cleared and holds unknown data until loaded
module canopen_node_boot_configurator_core (
   input  logic                             clock,
   input  logic                             reset,
   cnbc_req_if.sink                         req_bus,
   cnbc_rsp_if.source                       rsp_bus,
   input  logic                             csr_we,
   input  logic [cnbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cnbc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cnbc_pkg::*;

   // configuration registers
   logic [2:0]  node_count_ff;
   logic [27:0] node_ids_ff;
   logic [19:0] conf_lengths_ff;

   // per-node state, small enough for flops
   phase_type        phase_ff [MAX_NODES];
   phase_type        phase_in [MAX_NODES];
   logic [POS_W-1:0] pos_ff   [MAX_NODES];
   logic [POS_W-1:0] pos_in   [MAX_NODES];

   // configuration table memory, two registered read ports
   conf_entry_type   table_mem [TABLE_DEPTH];
   conf_entry_type   rd_a_ff;
   conf_entry_type   rd_b_ff;

   // stage 1: accepted request, table data available from the read registers
   logic              s1_valid_ff;
   cmd_type           s1_cmd_ff;
   logic              s1_hit_ff;
   logic [SLOT_W-1:0] s1_slot_ff;
   logic [10:0]       s1_can_id_ff;
   logic [3:0]        s1_len_ff;
   logic [63:0]       s1_payload_ff;

   // result register
   logic        out_valid_ff;
   logic        out_kind_ff;
   logic [10:0] out_id_ff;
   logic [3:0]  out_len_ff;
   logic [63:0] out_data_ff;
   logic [1:0]  out_slot_ff;
   logic [3:0]  out_function_ff;

   logic req_fire;
   logic s1_adv;

   // -------------------------------------------------------------------
   // handshake: stage 1 moves whenever the result register is free or drains
   // -------------------------------------------------------------------
   assign s1_adv        = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // -------------------------------------------------------------------
   // configuration writes
   // -------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff   <= '0;
         node_ids_ff     <= '0;
         conf_lengths_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NODE_COUNT:   node_count_ff   <= csr_wdata[2:0];
            CSR_NODE_IDS:     node_ids_ff     <= csr_wdata[27:0];
            CSR_CONF_LENGTHS: conf_lengths_ff <= csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------------
   // stage 0: node match and table addressing at acceptance
   // -------------------------------------------------------------------
   logic [2:0]        act_count;
   logic              hit0;
   logic [SLOT_W-1:0] slot0;
   logic [POS_W-1:0]  pos_cur;
   logic [POS_W-1:0]  pos_a;
   logic [POS_W-1:0]  pos_b;
   logic [ADDR_W-1:0] rd_a_addr;
   logic [ADDR_W-1:0] rd_b_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              load_we;
   conf_entry_type    load_entry;

   // counts beyond the slot range act as the full range
   assign act_count = (int'(node_count_ff) > MAX_NODES) ? 3'(MAX_NODES) : node_count_ff;

   always_comb begin
      hit0  = 1'b0;
      slot0 = '0;
      // walk down so the lowest matching slot is the one kept
      for (int s = MAX_NODES - 1; s >= 0; s--) begin
         if ((s < int'(act_count)) && (node_ids_ff[7*s +: 7] == req_bus.can_id[6:0])) begin
            hit0  = 1'b1;
            slot0 = SLOT_W'(s);
         end
      end
   end

   // position forwarded from stage 1 so back-to-back frames of one node
   // address the entry the previous frame just moved to
   assign pos_cur   = pos_in[slot0];
   assign pos_a     = (req_bus.can_id[10:7] == FC_BOOTUP) ? '0 : pos_cur;
   assign pos_b     = POS_W'(pos_cur + 1'b1);
   assign rd_a_addr = ADDR_W'(int'(slot0) * CONF_DEPTH + int'(ENTRY_W'(pos_a)));
   assign rd_b_addr = ADDR_W'(int'(slot0) * CONF_DEPTH + int'(ENTRY_W'(pos_b)));

   assign load_we = req_fire && (cmd_type'(req_bus.cmd) == CMD_LOAD)
                    && (int'(req_bus.node_slot) < MAX_NODES)
                    && (int'(req_bus.entry_slot) < CONF_DEPTH);
   assign wr_addr = ADDR_W'(int'(req_bus.node_slot) * CONF_DEPTH
                            + int'(req_bus.entry_slot));

   always_comb begin
      load_entry.index    = req_bus.entry_index;
      load_entry.subindex = req_bus.entry_subindex;
      load_entry.size     = req_bus.entry_size;
      load_entry.value    = req_bus.entry_value;
   end

   // table writes and reads both happen at the acceptance edge; every accepted
   // transaction reads the table, and a load also writes it
   always_ff @(posedge clock) begin
      if (load_we) begin
         table_mem[wr_addr] <= load_entry;
      end
      if (req_fire) begin
         rd_a_ff <= table_mem[rd_a_addr];
         rd_b_ff <= table_mem[rd_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff     <= cmd_type'(req_bus.cmd);
         s1_hit_ff     <= hit0;
         s1_slot_ff    <= slot0;
         s1_can_id_ff  <= req_bus.can_id;
         s1_len_ff     <= req_bus.frame_len;
         s1_payload_ff <= req_bus.payload;
      end
   end

   // -------------------------------------------------------------------
   // stage 1: node state update and result build
   // -------------------------------------------------------------------
   logic [3:0]       fc1;
   logic [6:0]       node1;
   logic [4:0]       len_raw;
   logic [POS_W-1:0] slot_len;
   logic [POS_W-1:0] pos1;
   logic [POS_W-1:0] pos1_next;
   phase_type        phase1;
   logic             sdo_match;
   logic [3:0]       pdo_len;
   logic [63:0]      pdo_data;
   conf_entry_type   sel_entry;
   logic             send_sdo;
   logic             send_start;

   logic        res_valid;
   logic        res_kind;
   logic [10:0] res_id;
   logic [3:0]  res_len;
   logic [63:0] res_data;
   logic [1:0]  res_slot;
   logic [3:0]  res_function;

   assign fc1       = s1_can_id_ff[10:7];
   assign node1     = s1_can_id_ff[6:0] & NODE_ID_MASK;
   assign len_raw   = conf_lengths_ff[5*int'(s1_slot_ff) +: 5];
   // table length clamps to the per-node configuration depth
   assign slot_len  = (int'(len_raw) > CONF_DEPTH) ? POS_W'(CONF_DEPTH) : POS_W'(len_raw);
   assign pos1      = pos_ff[s1_slot_ff];
   assign pos1_next = POS_W'(pos1 + 1'b1);
   assign phase1    = phase_ff[s1_slot_ff];
   assign sdo_match = (rd_a_ff.index == s1_payload_ff[23:8])
                      && (rd_a_ff.subindex == s1_payload_ff[31:24]);
   assign pdo_len   = (s1_len_ff > 4'd8) ? 4'd8 : s1_len_ff;

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         pdo_data[8*b +: 8] = (b < int'(pdo_len)) ? s1_payload_ff[8*b +: 8] : 8'h00;
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      sel_entry    = rd_a_ff;
      send_sdo     = 1'b0;
      send_start   = 1'b0;
      res_valid    = 1'b0;
      res_kind     = 1'b0;
      res_id       = '0;
      res_len      = '0;
      res_data     = '0;
      res_slot     = '0;
      res_function = '0;
      if (s1_adv) begin
         unique case (s1_cmd_ff)
            CMD_FRAME: begin
               if (s1_hit_ff) begin
                  if (fc1 inside {FC_PDO1, FC_PDO2, FC_PDO3}) begin
                     phase_in[s1_slot_ff] = PHASE_OPER;
                     res_valid    = 1'b1;
                     res_kind     = 1'b1;
                     res_id       = s1_can_id_ff;
                     res_len      = pdo_len;
                     res_data     = pdo_data;
                     res_slot     = 2'(s1_slot_ff);
                     res_function = fc1;
                  end else if (fc1 == FC_SDO_RESP) begin
                     // only an awaited response for the pending entry advances
                     if ((phase1 == PHASE_PREOP) && (pos1 < slot_len) && sdo_match) begin
                        pos_in[s1_slot_ff] = pos1_next;
                        if (pos1_next < slot_len) begin
                           send_sdo  = 1'b1;
                           sel_entry = rd_b_ff;
                        end else begin
                           send_start = 1'b1;
                        end
                     end
                  end else if (fc1 == FC_BOOTUP) begin
                     phase_in[s1_slot_ff] = PHASE_PREOP;
                     pos_in[s1_slot_ff]   = '0;
                     if (slot_len == '0) begin
                        send_start = 1'b1;
                     end else begin
                        send_sdo = 1'b1;
                     end
                  end
               end
            end
            CMD_LOAD: ;
            CMD_RESET_ALL: begin
               res_valid = 1'b1;
               res_id    = NMT_ID;
               res_len   = 4'd2;
               res_data  = {56'h0, NMT_RESET_ALL};
            end
            CMD_SYNC: begin
               res_valid = 1'b1;
               res_id    = SYNC_ID;
            end
            default: ;
         endcase

         if (send_start) begin
            res_valid = 1'b1;
            res_id    = NMT_ID;
            res_len   = 4'd2;
            res_data  = {48'h0, 1'b0, node1, NMT_START};
         end

         if (send_sdo) begin
            res_id = {FC_SDO_REQ, node1};
            // a bad size sends nothing; after an sdo response the position has moved on regardless
            case (sel_entry.size)
               3'd1: begin
                  res_valid = 1'b1;
                  res_len   = 4'd5;
                  res_data  = {24'h0, sel_entry.value[7:0], sel_entry.subindex,
                               sel_entry.index, SDO_DL_1};
               end
               3'd2: begin
                  res_valid = 1'b1;
                  res_len   = 4'd6;
                  res_data  = {16'h0, sel_entry.value[15:0], sel_entry.subindex,
                               sel_entry.index, SDO_DL_2};
               end
               3'd3: begin
                  res_valid = 1'b1;
                  res_len   = 4'd7;
                  res_data  = {8'h0, sel_entry.value[23:0], sel_entry.subindex,
                               sel_entry.index, SDO_DL_3};
               end
               3'd4: begin
                  res_valid = 1'b1;
                  res_len   = 4'd8;
                  res_data  = {sel_entry.value, sel_entry.subindex,
                               sel_entry.index, SDO_DL_4};
               end
               default: res_id = '0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < MAX_NODES; s++) begin
            phase_ff[s] <= PHASE_RESET_COM;
            pos_ff[s]   <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

   // -------------------------------------------------------------------
   // result register, parts stage 1 from the response side
   // -------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= res_valid;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && res_valid) begin
         out_kind_ff     <= res_kind;
         out_id_ff       <= res_id;
         out_len_ff      <= res_len;
         out_data_ff     <= res_data;
         out_slot_ff     <= res_slot;
         out_function_ff <= res_function;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.kind         = out_kind_ff;
   assign rsp_bus.out_id       = out_id_ff;
   assign rsp_bus.out_len      = out_len_ff;
   assign rsp_bus.out_data     = out_data_ff;
   assign rsp_bus.out_slot     = out_slot_ff;
   assign rsp_bus.out_function = out_function_ff;

endmodule

// ===== hw/rtl/cnbc_checker.sv =====
`timescale 1ns / 1ps
`include "canopen_node_boot_configurator_core_assert.svh"
module cnbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [10:0] rsp_out_id,
   input logic [3:0]  rsp_out_len,
   input logic [63:0] rsp_out_data,
   input logic [1:0]  rsp_out_slot,
   input logic [3:0]  rsp_out_function
);
   import cnbc_pkg::*;

   // nothing is offered right after reset
   `CNBC_ASSERT_NXT(a_reset_idle, clock, reset, !rsp_valid)

   // transmitted frames carry no slot or function tag
   `CNBC_ASSERT_IMP(a_tx_untagged, clock, reset, rsp_valid && !rsp_kind,
      rsp_out_slot == 2'd0 && rsp_out_function == 4'd0)

   // delivered frames are pdos whose tag agrees with the identifier
   `CNBC_ASSERT_IMP(a_pdo_tag, clock, reset, rsp_valid && rsp_kind,
      (rsp_out_function == FC_PDO1 || rsp_out_function == FC_PDO2
       || rsp_out_function == FC_PDO3)
      && rsp_out_id[10:7] == rsp_out_function && rsp_out_len <= 4'd8)

   // a stalled transaction holds
   `CNBC_ASSERT_NXT(a_rsp_hold, clock, !reset && rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_id) && $stable(rsp_out_data))

endmodule

bind canopen_node_boot_configurator_core cnbc_checker u_cnbc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_kind         (rsp_bus.kind),
   .rsp_out_id       (rsp_bus.out_id),
   .rsp_out_len      (rsp_bus.out_len),
   .rsp_out_data     (rsp_bus.out_data),
   .rsp_out_slot     (rsp_bus.out_slot),
   .rsp_out_function (rsp_bus.out_function)
);
